### hw/rtl/wps_pkg.sv
// ----------------------------------------------------------------------------
// wps_pkg: shared types and constants of the RIFF/WAVE PCM16 stream parser
// Holds the result record, the push bundle from the parser to the output
// queue, the status codes and the four-character tags.
// ----------------------------------------------------------------------------
package wps_pkg;

  // Result kinds
  localparam logic KindSample = 1'b0;
  localparam logic KindStatus = 1'b1;

  // Final status codes
  localparam logic [3:0] StatusOk           = 4'd0;
  localparam logic [3:0] StatusChannels     = 4'd1;
  localparam logic [3:0] StatusShort        = 4'd2;
  localparam logic [3:0] StatusBits         = 4'd3;
  localparam logic [3:0] StatusRiff         = 4'd4;
  localparam logic [3:0] StatusWave         = 4'd5;
  localparam logic [3:0] StatusFmtTruncated = 4'd6;
  localparam logic [3:0] StatusNotFmt       = 4'd7;
  localparam logic [3:0] StatusNotPcm       = 4'd8;
  localparam logic [3:0] StatusDataMissing  = 4'd9;

  // Chunk tags, first byte of the file in the top byte
  localparam logic [31:0] TagRiff = 32'h5249_4646;
  localparam logic [31:0] TagWave = 32'h5741_5645;
  localparam logic [31:0] TagFmt  = 32'h666D_7420;
  localparam logic [31:0] TagData = 32'h6461_7461;

  // Header layout
  localparam int unsigned HeaderLastPos = 19;
  localparam int unsigned ChunkHdrLastPos = 7;

  // Accepted fmt values
  localparam logic [15:0] FormatPcm    = 16'd1;
  localparam logic [15:0] ChannelsMono = 16'd1;
  localparam logic [15:0] ChannelsStereo = 16'd2;
  localparam logic [15:0] BitsPcm16    = 16'd16;

  typedef struct packed {
    logic        kind;
    logic [15:0] sample_value;
    logic [3:0]  status;
    logic [1:0]  channel_count;
    logic [31:0] rate_value;
  } wps_result_t;

  // Up to two results per byte, in order; res1 only with res0
  typedef struct packed {
    logic        res0_vld;
    wps_result_t res0;
    logic        res1_vld;
    wps_result_t res1;
  } wps_push_t;

endpackage

### hw/rtl/wps_parser.sv
// ----------------------------------------------------------------------------
// wps_parser: byte-wise RIFF/WAVE header and chunk parser
// Updates the parse state on each transferred byte and produces the sample
// and status results that byte causes, in order, for the output queue.
// ----------------------------------------------------------------------------
module wps_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        file_byte_i,
  input  logic              end_of_file_i,
  output wps_pkg::wps_push_t push_o
);
  import wps_pkg::*;

  typedef enum logic [2:0] {
    PhHeader,
    PhFmt,
    PhChunkHdr,
    PhSkip,
    PhData
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [31:0] pos_q, pos_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [1:0]  magic_q, magic_d;
  logic [15:0] fmt_q, fmt_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic [7:0]  low_q, low_d;
  logic        fin_q, fin_d;

  logic        samp_vld;
  logic [15:0] samp_word;
  logic        stat_vld;
  logic [3:0]  stat_code;
  logic [3:0]  judge_code;
  logic [31:0] pos_inc;
  logic [31:0] byte_ext;
  logic        stat_acc;
  wps_result_t samp_res;
  wps_result_t stat_res;

  // Verdict on the first chunk, checked in file order
  function automatic logic [3:0] judge_first(input logic [31:0] tag,
                                             input logic [15:0] fmt,
                                             input logic [15:0] chan,
                                             input logic [15:0] bits);
    logic [3:0] code;
    code = StatusOk;
    if (tag != TagFmt) begin
      code = StatusNotFmt;
    end else if (fmt != FormatPcm) begin
      code = StatusNotPcm;
    end else if (chan != ChannelsMono && chan != ChannelsStereo) begin
      code = StatusChannels;
    end else if (bits != BitsPcm16) begin
      code = StatusBits;
    end
    return code;
  endfunction

  assign pos_inc  = pos_q + 32'd1;
  assign byte_ext = {24'd0, file_byte_i};

  // Advance the parse state for one byte
  always_comb begin
    phase_d    = phase_q;
    pos_d      = pos_q;
    tag_d      = tag_q;
    len_d      = len_q;
    magic_d    = magic_q;
    fmt_d      = fmt_q;
    chan_d     = chan_q;
    rate_d     = rate_q;
    bits_d     = bits_q;
    low_d      = low_q;
    fin_d      = fin_q;
    samp_vld   = 1'b0;
    samp_word  = {file_byte_i, low_q};
    stat_vld   = 1'b0;
    stat_code  = StatusOk;
    judge_code = StatusOk;

    if (accept_i && !fin_q) begin
      case (phase_q)
        PhHeader: begin
          // Check magic, collect first chunk tag and length
          if (pos_q < 32'd4) begin
            if (file_byte_i != TagRiff[{~pos_q[1:0], 3'b000} +: 8]) begin
              magic_d[0] = 1'b1;
            end
          end else if (pos_q >= 32'd8 && pos_q < 32'd12) begin
            if (file_byte_i != TagWave[{~pos_q[1:0], 3'b000} +: 8]) begin
              magic_d[1] = 1'b1;
            end
          end else if (pos_q >= 32'd12 && pos_q < 32'd16) begin
            tag_d = {tag_q[23:0], file_byte_i};
          end else if (pos_q >= 32'd16 && pos_q < 32'd20) begin
            len_d = len_q | (byte_ext << {pos_q[1:0], 3'b000});
          end
          if (pos_q >= 32'(HeaderLastPos)) begin
            if (magic_d[0]) begin
              stat_vld  = 1'b1;
              stat_code = StatusRiff;
              fin_d     = 1'b1;
            end else if (magic_d[1]) begin
              stat_vld  = 1'b1;
              stat_code = StatusWave;
              fin_d     = 1'b1;
            end else if (len_d == 32'd0) begin
              // Empty first chunk: judge it right away
              judge_code = judge_first(tag_d, fmt_d, chan_d, bits_d);
              if (judge_code != StatusOk) begin
                stat_vld  = 1'b1;
                stat_code = judge_code;
                fin_d     = 1'b1;
              end else begin
                phase_d = PhChunkHdr;
                pos_d   = 32'd0;
                tag_d   = 32'd0;
                len_d   = 32'd0;
              end
            end else begin
              phase_d = PhFmt;
              pos_d   = 32'd0;
            end
          end else begin
            pos_d = pos_inc;
          end
        end

        PhFmt: begin
          // Capture fmt fields; bytes past the chunk never arrive here
          if (pos_q < 32'd2) begin
            fmt_d = fmt_q | (16'(file_byte_i) << {pos_q[0], 3'b000});
          end else if (pos_q < 32'd4) begin
            chan_d = chan_q | (16'(file_byte_i) << {pos_q[0], 3'b000});
          end else if (pos_q < 32'd8) begin
            rate_d = rate_q | (byte_ext << {pos_q[1:0], 3'b000});
          end else if (pos_q == 32'd14 || pos_q == 32'd15) begin
            bits_d = bits_q | (16'(file_byte_i) << {pos_q[0], 3'b000});
          end
          pos_d = pos_inc;
          if (pos_inc >= len_q) begin
            judge_code = judge_first(tag_d, fmt_d, chan_d, bits_d);
            if (judge_code != StatusOk) begin
              stat_vld  = 1'b1;
              stat_code = judge_code;
              fin_d     = 1'b1;
            end else begin
              phase_d = PhChunkHdr;
              pos_d   = 32'd0;
              tag_d   = 32'd0;
              len_d   = 32'd0;
            end
          end
        end

        PhChunkHdr: begin
          // Collect tag and length, then pick data, skip or next header
          if (pos_q < 32'd4) begin
            tag_d = {tag_q[23:0], file_byte_i};
          end else if (pos_q < 32'd8) begin
            len_d = len_q | (byte_ext << {pos_q[1:0], 3'b000});
          end
          if (pos_q >= 32'(ChunkHdrLastPos)) begin
            pos_d = 32'd0;
            if (tag_d == TagData) begin
              if (len_d == 32'd0) begin
                stat_vld  = 1'b1;
                stat_code = StatusOk;
                fin_d     = 1'b1;
              end else begin
                phase_d = PhData;
              end
            end else if (len_d == 32'd0) begin
              tag_d = 32'd0;
              len_d = 32'd0;
            end else begin
              phase_d = PhSkip;
            end
          end else begin
            pos_d = pos_inc;
          end
        end

        PhSkip: begin
          // Drop the body of an unknown chunk
          pos_d = pos_inc;
          if (pos_inc >= len_q) begin
            phase_d = PhChunkHdr;
            pos_d   = 32'd0;
            tag_d   = 32'd0;
            len_d   = 32'd0;
          end
        end

        PhData: begin
          // Pair bytes into little-endian words
          if (pos_q[0]) begin
            samp_vld = 1'b1;
          end else begin
            low_d = file_byte_i;
          end
          pos_d = pos_inc;
          if (pos_inc >= len_q) begin
            stat_vld  = 1'b1;
            stat_code = StatusOk;
            fin_d     = 1'b1;
          end
        end

        default: begin
          phase_d = PhHeader;
          pos_d   = 32'd0;
        end
      endcase

      // End of file before a verdict
      if (!fin_d && end_of_file_i) begin
        stat_vld = 1'b1;
        fin_d    = 1'b1;
        if (phase_d == PhHeader) begin
          stat_code = StatusShort;
        end else if (phase_d == PhFmt) begin
          stat_code = StatusFmtTruncated;
        end else begin
          stat_code = StatusDataMissing;
        end
      end
    end
  end

  // Format fields are reported only once the fmt chunk has passed
  assign stat_acc = (stat_code == StatusOk) || (stat_code == StatusDataMissing);

  always_comb begin
    samp_res.kind          = KindSample;
    samp_res.sample_value  = samp_word;
    samp_res.status        = StatusOk;
    samp_res.channel_count = chan_d[1:0];
    samp_res.rate_value    = rate_d;

    stat_res.kind          = KindStatus;
    stat_res.sample_value  = 16'd0;
    stat_res.status        = stat_code;
    stat_res.channel_count = stat_acc ? chan_d[1:0] : 2'd0;
    stat_res.rate_value    = stat_acc ? rate_d : 32'd0;
  end

  // Order the results: sample first, then status
  always_comb begin
    push_o.res0_vld = samp_vld || stat_vld;
    push_o.res0     = samp_vld ? samp_res : stat_res;
    push_o.res1_vld = samp_vld && stat_vld;
    push_o.res1     = stat_res;
  end

  // Hold parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHeader;
      pos_q   <= '0;
      tag_q   <= '0;
      len_q   <= '0;
      magic_q <= '0;
      fmt_q   <= '0;
      chan_q  <= '0;
      rate_q  <= '0;
      bits_q  <= '0;
      low_q   <= '0;
      fin_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      magic_q <= magic_d;
      fmt_q   <= fmt_d;
      chan_q  <= chan_d;
      rate_q  <= rate_d;
      bits_q  <= bits_d;
      low_q   <= low_d;
      fin_q   <= fin_d;
    end
  end

  // Nothing follows the final status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> !push_o.res0_vld)
    else $error("result produced after final status");

  // A status always closes the file
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.res0_vld && push_o.res0.kind == KindStatus) || push_o.res1_vld |=> fin_q)
    else $error("status did not end the file");

endmodule

### hw/rtl/wps_out_fifo.sv
// ----------------------------------------------------------------------------
// wps_out_fifo: result queue between the parser and the output channel
// Takes up to two results per cycle and hands out one per transfer. Reports
// full when fewer than two entries are free.
// ----------------------------------------------------------------------------
module wps_out_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wps_pkg::wps_push_t push_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output wps_pkg::wps_result_t out_o
);
  import wps_pkg::*;

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = PtrW + 1;

  wps_result_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     push_n;
  logic                pop;
  logic [PtrW-1:0]     wr_ptr_nx;

  assign push_n    = CntW'(push_i.res0_vld) + CntW'(push_i.res1_vld);
  assign pop       = out_valid_o && !out_stall_i;
  assign wr_ptr_nx = wr_ptr_q + PtrW'(1);

  assign out_valid_o = (count_q != '0);
  assign out_o       = mem_q[rd_ptr_q];
  assign full_o      = (count_q > CntW'(Depth - 2));

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q + push_n[PtrW-1:0];
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + push_n - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Write results in order
  always_ff @(posedge clk_i) begin
    if (push_i.res0_vld) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.res1_vld) begin
      mem_q[wr_ptr_nx] <= push_i.res1;
    end
  end

  // Never overfill
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("output queue overflow");

  // Pushes only arrive while two entries are free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i.res0_vld)
    else $error("push into full output queue");

endmodule

### hw/rtl/wav_pcm16_stream_parser_top.sv
// ----------------------------------------------------------------------------
// wav_pcm16_stream_parser_top: RIFF/WAVE PCM16 stream parser
// Takes one byte of a wave file per transfer and returns audio sample words
// followed by one final status.
// ----------------------------------------------------------------------------
// The block takes one file byte per clock cycle while in_stall_o is low, with
// end_of_file_i marking the last byte. Each byte is parsed in the cycle of its
// transfer and its results (at most two: a sample and the final status) enter
// an output queue of FifoDepth entries (a power of two, at least 4), from
// which they leave one per transfer starting the next cycle. in_stall_o rises
// only while fewer than two queue entries are free, so with the output side
// taking a result every cycle the input runs at one byte per cycle without a
// break. After the final status further transferred bytes are ignored until
// reset. Samples of a truncated data chunk are delivered before a data-missing
// status, so check the status before trusting them.
// ----------------------------------------------------------------------------
module wav_pcm16_stream_parser_top #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  file_byte_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        kind_o,
  output logic [15:0] sample_value_o,
  output logic [3:0]  status_o,
  output logic [1:0]  channel_count_o,
  output logic [31:0] rate_value_o
);
  import wps_pkg::*;

  wps_push_t   push;
  wps_result_t out_res;
  logic        fifo_full;
  logic        in_xfer;

  // Take a byte when the queue has room for two results
  assign in_stall_o = fifo_full;
  assign in_xfer    = in_valid_i && !in_stall_o;

  wps_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_xfer),
    .file_byte_i   (file_byte_i),
    .end_of_file_i (end_of_file_i),
    .push_o        (push)
  );

  wps_out_fifo #(
    .Depth (FifoDepth)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (fifo_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign kind_o          = out_res.kind;
  assign sample_value_o  = out_res.sample_value;
  assign status_o        = out_res.status;
  assign channel_count_o = out_res.channel_count;
  assign rate_value_o    = out_res.rate_value;

endmodule
